// ===== rtl/core/ctre_pkg.sv =====
// Shared types and constants for the cyclic tour reversal engine.
package ctre_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 7;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int POS_W     = 6;
    localparam int IN_W      = 40;
    localparam int OUT_W     = 40;

    // Opcode values of the input word.
    localparam logic [3:0] OP_INIT   = 4'd0;
    localparam logic [3:0] OP_EDGE   = 4'd1;
    localparam logic [3:0] OP_REV    = 4'd2;
    localparam logic [3:0] OP_SWITCH = 4'd3;
    localparam logic [3:0] OP_LADDER = 4'd4;
    localparam logic [3:0] OP_COUNT  = 4'd5;
    localparam logic [3:0] OP_QUERY  = 4'd6;
    localparam logic [3:0] OP_CLEAR  = 4'd7;
    localparam logic [3:0] OP_MARK   = 4'd8;
    localparam logic [3:0] OP_TEST   = 4'd9;

    // Command kinds after decode and operand checking.
    typedef enum logic [3:0] {
        K_INIT, K_EDGE, K_REV, K_SWITCH, K_LADDER, K_COUNT,
        K_QUERY, K_CLEAR, K_MARK, K_TEST, K_BAD, K_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [NODE_W-1:0]   node_c;
        logic [NODE_W-1:0]   node_d;
        logic                edge_bit;
    } cmd_t;

    // Result word, first field in the highest bits.
    typedef struct packed {
        logic                bad_node;
        logic                gap_marked;
        logic [POS_W-1:0]    position;
        logic [NODE_W-1:0]   prev_node;
        logic [NODE_W-1:0]   succ_node;
        logic [NODE_W-1:0]   gap_total;
        logic [NODE_W-1:0]   ladder_hit;
    } res_t;

    typedef enum logic [4:0] {
        S_IDLE, S_REV_P, S_REV_L, S_REV_R, S_REV_W,
        S_LAD_P, S_LAD_Q, S_LAD_T, S_LAD_A,
        S_CNT_T, S_CNT_A, S_CNT_C,
        S_QRY_P, S_QRY_T, S_QRY_D,
        S_ADJ_R, S_ADJ_W,
        S_GAP_R1, S_GAP_W1, S_GAP_R2, S_GAP_W2,
        S_TST_R, S_TST_D
    } st_t;

endpackage

// ===== rtl/core/ctre_front.sv =====
// Front end: unpacks an input word, checks operands and classifies the command.
module ctre_front (
    input  logic [ctre_pkg::IN_W-1:0]   s_tdata,
    input  logic [ctre_pkg::NODE_W-1:0] eff_n,
    output ctre_pkg::cmd_t              cmd
);
    import ctre_pkg::*;

    logic [3:0]        opcode;
    logic [NODE_W-1:0] na, nb, nc, nd;
    logic              ok_a, ok_b, ok_c, ok_d;

    // Field unpacking, opcode in the lowest bits.
    assign opcode = s_tdata[3:0];
    assign na     = s_tdata[10:4];
    assign nb     = s_tdata[17:11];
    assign nc     = s_tdata[24:18];
    assign nd     = s_tdata[31:25];

    // A node operand is valid when it lies in 1..n.
    assign ok_a = (na != '0) && (na <= eff_n);
    assign ok_b = (nb != '0) && (nb <= eff_n);
    assign ok_c = (nc != '0) && (nc <= eff_n);
    assign ok_d = (nd != '0) && (nd <= eff_n);

    // Command classification.
    always_comb
    begin
        cmd.node_a   = na;
        cmd.node_b   = nb;
        cmd.node_c   = nc;
        cmd.node_d   = nd;
        cmd.edge_bit = s_tdata[32];
        case (opcode)
            OP_INIT:   cmd.kind = K_INIT;
            OP_EDGE:   cmd.kind = (ok_a && ok_b) ? K_EDGE : K_BAD;
            OP_REV:    cmd.kind = (ok_a && ok_b) ? K_REV : K_BAD;
            OP_SWITCH: cmd.kind = (ok_a && ok_b && ok_c && ok_d) ? K_SWITCH : K_BAD;
            OP_LADDER: cmd.kind = (ok_a && ok_b && ok_c) ? K_LADDER : K_BAD;
            OP_COUNT:  cmd.kind = K_COUNT;
            OP_QUERY:  cmd.kind = ok_a ? K_QUERY : K_BAD;
            OP_CLEAR:  cmd.kind = K_CLEAR;
            OP_MARK:   cmd.kind = (ok_a && ok_b) ? K_MARK : K_BAD;
            OP_TEST:   cmd.kind = (ok_a && ok_b) ? K_TEST : K_BAD;
            default:   cmd.kind = K_NOP;
        endcase
    end

endmodule

// ===== rtl/core/ctre_queue.sv =====
// Two-entry command queue between the front end and the execution unit.
module ctre_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ctre_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output ctre_pkg::cmd_t pop_data
);
    import ctre_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/ctre_back.sv =====
// Execution unit: tour, position, adjacency and gap-mark memories and the sequencer.
module ctre_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ctre_pkg::NODE_W-1:0] eff_n,
    input  logic                        cfg_init,
    input  logic                        q_valid,
    input  ctre_pkg::cmd_t              q_data,
    output logic                        q_pop,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output ctre_pkg::res_t              m_res
);
    import ctre_pkg::*;

    // Node number to memory index.
    function automatic logic [IDX_W-1:0] nidx(input logic [NODE_W-1:0] v);
        logic [NODE_W-1:0] t;
        t = v - NODE_W'(1);
        return t[IDX_W-1:0];
    endfunction

    // Position step forward and backward around the tour of length n.
    function automatic logic [IDX_W-1:0] inc_w(input logic [IDX_W-1:0] x,
                                               input logic [NODE_W-1:0] n);
        logic [NODE_W-1:0] s;
        s = NODE_W'(x) + NODE_W'(1);
        return (s >= n) ? '0 : s[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] dec_w(input logic [IDX_W-1:0] x,
                                               input logic [NODE_W-1:0] n);
        logic [NODE_W-1:0] s;
        s = n - NODE_W'(1);
        return (x == '0) ? s[IDX_W-1:0] : x - IDX_W'(1);
    endfunction

    // Memories; an entry without its valid bit reads as its reset value.
    logic [NODE_W-1:0]    tour_mem [MAX_NODES];
    logic [POS_W-1:0]     pos_mem  [MAX_NODES];
    logic [MAX_NODES-1:0] adj_mem  [MAX_NODES];
    logic [MAX_NODES-1:0] gap_mem  [MAX_NODES];
    logic [MAX_NODES-1:0] tour_vld_reg, pos_vld_reg, adj_vld_reg, gap_vld_reg;

    logic [IDX_W-1:0]     t_ra0, t_ra1, p_ra0, p_ra1, a_ra, g_ra;
    logic                 t_we, p_we, a_we, g_we;
    logic [IDX_W-1:0]     t_wa, p_wa, a_wa, g_wa;
    logic [NODE_W-1:0]    t_wd;
    logic [POS_W-1:0]     p_wd;
    logic [MAX_NODES-1:0] a_wd, g_wd;
    logic                 init_clr, gap_clr;

    logic [NODE_W-1:0]    t_d0_reg, t_d1_reg;
    logic [POS_W-1:0]     p_d0_reg, p_d1_reg;
    logic [MAX_NODES-1:0] a_d_reg, g_d_reg;
    logic                 t_v0_reg, t_v1_reg, p_v0_reg, p_v1_reg, a_v_reg, g_v_reg;
    logic [IDX_W-1:0]     t_a0_reg, t_a1_reg, p_a0_reg, p_a1_reg;

    logic [NODE_W-1:0]    t0, t1;
    logic [IDX_W-1:0]     p0, p1;
    logic [MAX_NODES-1:0] arow, grow;

    // Memory writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            tour_mem[t_wa] <= t_wd;
        end
        if (p_we)
        begin
            pos_mem[p_wa] <= p_wd;
        end
        if (a_we)
        begin
            adj_mem[a_wa] <= a_wd;
        end
        if (g_we)
        begin
            gap_mem[g_wa] <= g_wd;
        end
        t_d0_reg <= tour_mem[t_ra0];
        t_d1_reg <= tour_mem[t_ra1];
        t_v0_reg <= tour_vld_reg[t_ra0];
        t_v1_reg <= tour_vld_reg[t_ra1];
        t_a0_reg <= t_ra0;
        t_a1_reg <= t_ra1;
        p_d0_reg <= pos_mem[p_ra0];
        p_d1_reg <= pos_mem[p_ra1];
        p_v0_reg <= pos_vld_reg[p_ra0];
        p_v1_reg <= pos_vld_reg[p_ra1];
        p_a0_reg <= p_ra0;
        p_a1_reg <= p_ra1;
        a_d_reg  <= adj_mem[a_ra];
        a_v_reg  <= adj_vld_reg[a_ra];
        g_d_reg  <= gap_mem[g_ra];
        g_v_reg  <= gap_vld_reg[g_ra];
    end

    // Valid bits: reset and init bring back the identity tour and empty marks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tour_vld_reg <= '0;
            pos_vld_reg  <= '0;
            adj_vld_reg  <= '0;
            gap_vld_reg  <= '0;
        end
        else
        begin
            if (init_clr)
            begin
                tour_vld_reg <= '0;
                pos_vld_reg  <= '0;
                gap_vld_reg  <= '0;
            end
            else
            begin
                if (t_we)
                begin
                    tour_vld_reg[t_wa] <= 1'b1;
                end
                if (p_we)
                begin
                    pos_vld_reg[p_wa] <= 1'b1;
                end
                if (gap_clr)
                begin
                    gap_vld_reg <= '0;
                end
                else if (g_we)
                begin
                    gap_vld_reg[g_wa] <= 1'b1;
                end
            end
            if (a_we)
            begin
                adj_vld_reg[a_wa] <= 1'b1;
            end
        end
    end

    // Effective read data.
    assign t0   = t_v0_reg ? t_d0_reg : NODE_W'(t_a0_reg) + NODE_W'(1);
    assign t1   = t_v1_reg ? t_d1_reg : NODE_W'(t_a1_reg) + NODE_W'(1);
    assign p0   = p_v0_reg ? p_d0_reg[IDX_W-1:0] : p_a0_reg;
    assign p1   = p_v1_reg ? p_d1_reg[IDX_W-1:0] : p_a1_reg;
    assign arow = a_v_reg ? a_d_reg : '0;
    assign grow = g_v_reg ? g_d_reg : '0;

    // Sequencer registers.
    st_t               state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [IDX_W-1:0]  ia_reg, ia_next, ib_reg, ib_next;
    logic [IDX_W-1:0]  k_reg, k_next, i_reg, i_next, p_reg, p_next;
    logic [1:0]        seg_reg, seg_next;
    logic [NODE_W-1:0] na_reg, na_next, cur_reg, cur_next, cnt_reg, cnt_next;
    res_t              out_reg, out_next;
    logic              out_vld_reg, out_vld_next;

    logic [NODE_W-1:0] seg_a, seg_b, len, cnt_sum;
    logic [IDX_W-1:0]  nxt_a, nxt_b;
    logic              fin;
    res_t              res;

    assign m_tvalid = out_vld_reg;
    assign m_res    = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        ia_reg  <= ia_next;
        ib_reg  <= ib_next;
        k_reg   <= k_next;
        i_reg   <= i_next;
        p_reg   <= p_next;
        seg_reg <= seg_next;
        na_reg  <= na_next;
        cur_reg <= cur_next;
        cnt_reg <= cnt_next;
        out_reg <= out_next;
    end

    // Endpoints of the segment being reversed; switch runs three segments.
    always_comb
    begin
        case (seg_reg)
            2'd0:
            begin
                seg_a = cmd_reg.node_a;
                seg_b = (cmd_reg.kind == K_SWITCH) ? cmd_reg.node_d : cmd_reg.node_b;
            end
            2'd1:
            begin
                seg_a = cmd_reg.node_b;
                seg_b = cmd_reg.node_a;
            end
            default:
            begin
                seg_a = cmd_reg.node_d;
                seg_b = cmd_reg.node_c;
            end
        endcase
    end

    assign len     = (p0 > p1) ? eff_n - NODE_W'(p0) + NODE_W'(p1) + NODE_W'(1)
                               : NODE_W'(p1) - NODE_W'(p0) + NODE_W'(1);
    assign nxt_a   = inc_w(ia_reg, eff_n);
    assign nxt_b   = dec_w(ib_reg, eff_n);
    assign cnt_sum = cnt_reg + NODE_W'(!arow[nidx(cur_reg)]);

    // Next state, memory control and result.
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        p_next     = p_reg;
        seg_next   = seg_reg;
        na_next    = na_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        t_ra0 = '0; t_ra1 = '0; p_ra0 = '0; p_ra1 = '0; a_ra = '0; g_ra = '0;
        t_we = 1'b0; t_wa = '0; t_wd = '0;
        p_we = 1'b0; p_wa = '0; p_wd = '0;
        a_we = 1'b0; a_wa = '0; a_wd = '0;
        g_we = 1'b0; g_wa = '0; g_wd = '0;
        init_clr = cfg_init;
        gap_clr  = 1'b0;
        q_pop    = 1'b0;
        fin      = 1'b0;
        res      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !out_vld_reg)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    seg_next = 2'd0;
                    i_next   = '0;
                    cnt_next = '0;
                    case (q_data.kind)
                        K_INIT:   begin init_clr = 1'b1; fin = 1'b1; end
                        K_CLEAR:  begin gap_clr = 1'b1; fin = 1'b1; end
                        K_BAD:    begin res.bad_node = 1'b1; fin = 1'b1; end
                        K_EDGE:   state_next = S_ADJ_R;
                        K_REV:    state_next = S_REV_P;
                        K_SWITCH: state_next = S_REV_P;
                        K_LADDER: state_next = S_LAD_P;
                        K_COUNT:  state_next = S_CNT_T;
                        K_QUERY:  state_next = S_QRY_P;
                        K_MARK:   state_next = S_GAP_R1;
                        K_TEST:   state_next = S_TST_R;
                        default:  fin = 1'b1;
                    endcase
                end
            end

            // Reversal: look up both end positions, then swap pairs inward.
            S_REV_P:
            begin
                p_ra0      = nidx(seg_a);
                p_ra1      = nidx(seg_b);
                state_next = S_REV_L;
            end
            S_REV_L:
            begin
                if (len[NODE_W-1:1] == '0)
                begin
                    if ((cmd_reg.kind == K_SWITCH) && (seg_reg != 2'd2))
                    begin
                        seg_next   = seg_reg + 2'd1;
                        state_next = S_REV_P;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                else
                begin
                    t_ra0      = p0;
                    t_ra1      = p1;
                    ia_next    = p0;
                    ib_next    = p1;
                    k_next     = len[NODE_W-1:1];
                    state_next = S_REV_R;
                end
            end
            S_REV_R:
            begin
                t_we       = 1'b1;
                t_wa       = ia_reg;
                t_wd       = t1;
                p_we       = 1'b1;
                p_wa       = nidx(t1);
                p_wd       = POS_W'(ia_reg);
                na_next    = t0;
                state_next = S_REV_W;
            end
            S_REV_W:
            begin
                t_we   = 1'b1;
                t_wa   = ib_reg;
                t_wd   = na_reg;
                p_we   = 1'b1;
                p_wa   = nidx(na_reg);
                p_wd   = POS_W'(ib_reg);
                k_next = k_reg - IDX_W'(1);
                if (k_reg == IDX_W'(1))
                begin
                    if ((cmd_reg.kind == K_SWITCH) && (seg_reg != 2'd2))
                    begin
                        seg_next   = seg_reg + 2'd1;
                        state_next = S_REV_P;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                else
                begin
                    t_ra0      = nxt_a;
                    t_ra1      = nxt_b;
                    ia_next    = nxt_a;
                    ib_next    = nxt_b;
                    state_next = S_REV_R;
                end
            end

            // Ladder: walk forward from a until b, testing each node against c.
            S_LAD_P:
            begin
                if (cmd_reg.node_a == cmd_reg.node_b)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    p_ra0      = nidx(cmd_reg.node_a);
                    state_next = S_LAD_Q;
                end
            end
            S_LAD_Q:
            begin
                t_ra0      = inc_w(p0, eff_n);
                ia_next    = inc_w(p0, eff_n);
                state_next = S_LAD_T;
            end
            S_LAD_T:
            begin
                cur_next   = t0;
                a_ra       = nidx(t0);
                state_next = S_LAD_A;
            end
            S_LAD_A:
            begin
                if (arow[nidx(cmd_reg.node_c)])
                begin
                    res.ladder_hit = cur_reg;
                    fin            = 1'b1;
                end
                else if (cur_reg == cmd_reg.node_b)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    t_ra0      = nxt_a;
                    ia_next    = nxt_a;
                    state_next = S_LAD_T;
                end
            end

            // Gap count: one tour position per pass.
            S_CNT_T:
            begin
                t_ra0      = i_reg;
                t_ra1      = inc_w(i_reg, eff_n);
                state_next = S_CNT_A;
            end
            S_CNT_A:
            begin
                cur_next   = t1;
                a_ra       = nidx(t0);
                state_next = S_CNT_C;
            end
            S_CNT_C:
            begin
                cnt_next = cnt_sum;
                if (NODE_W'(i_reg) == eff_n - NODE_W'(1))
                begin
                    res.gap_total = cnt_sum;
                    fin           = 1'b1;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_CNT_T;
                end
            end

            // Query: position, then successor and predecessor.
            S_QRY_P:
            begin
                p_ra0      = nidx(cmd_reg.node_a);
                state_next = S_QRY_T;
            end
            S_QRY_T:
            begin
                p_next     = p0;
                t_ra0      = inc_w(p0, eff_n);
                t_ra1      = dec_w(p0, eff_n);
                state_next = S_QRY_D;
            end
            S_QRY_D:
            begin
                res.succ_node = t0;
                res.prev_node = t1;
                res.position  = POS_W'(p_reg);
                fin           = 1'b1;
            end

            // Adjacency bit write as a row read-modify-write.
            S_ADJ_R:
            begin
                a_ra       = nidx(cmd_reg.node_a);
                state_next = S_ADJ_W;
            end
            S_ADJ_W:
            begin
                a_we = 1'b1;
                a_wa = nidx(cmd_reg.node_a);
                a_wd = arow;
                a_wd[nidx(cmd_reg.node_b)] = cmd_reg.edge_bit;
                fin  = 1'b1;
            end

            // Gap mark sets both (a,b) and (b,a).
            S_GAP_R1:
            begin
                g_ra       = nidx(cmd_reg.node_a);
                state_next = S_GAP_W1;
            end
            S_GAP_W1:
            begin
                g_we = 1'b1;
                g_wa = nidx(cmd_reg.node_a);
                g_wd = grow;
                g_wd[nidx(cmd_reg.node_b)] = 1'b1;
                state_next = S_GAP_R2;
            end
            S_GAP_R2:
            begin
                g_ra       = nidx(cmd_reg.node_b);
                state_next = S_GAP_W2;
            end
            S_GAP_W2:
            begin
                g_we = 1'b1;
                g_wa = nidx(cmd_reg.node_b);
                g_wd = grow;
                g_wd[nidx(cmd_reg.node_a)] = 1'b1;
                fin  = 1'b1;
            end

            S_TST_R:
            begin
                g_ra       = nidx(cmd_reg.node_b);
                state_next = S_TST_D;
            end
            S_TST_D:
            begin
                res.gap_marked = grow[nidx(cmd_reg.node_a)];
                fin            = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = S_IDLE;
        end

        // Output register.
        out_next     = out_reg;
        out_vld_next = out_vld_reg;
        if (fin)
        begin
            out_next     = res;
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

endmodule

// ===== rtl/core/cyclic_tour_reversal_engine_top.sv =====
// Reverse swaps pairs of tour entries inward; switch reverses its three segments in turn.
// Ladder walks the tour one step at a time (no walk when a equals b); gap count visits each tour position.
// Throughput is one command at a time through the sequencer; a two-entry queue takes words ahead.
// Reset: node count 64, identity tour, no edges, no marks, cleared at once by valid flops.
// Top level of the cyclic tour reversal engine.
module cyclic_tour_reversal_engine_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[3:0], node_a[10:4], node_b[17:11], node_c[24:18], node_d[31:25],
    // edge_bit[32], zero fill [39:33]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ladder_hit[6:0], gap_total[13:7], succ_node[20:14], prev_node[27:21],
    // position[33:28], gap_marked[34], bad_node[35], zero fill [39:36]
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);
    import ctre_pkg::*;

    logic [NODE_W-1:0] node_count_reg;
    logic [NODE_W-1:0] eff_n;
    cmd_t              f_cmd, q_cmd;
    logic              q_full, q_valid, q_pop, push;
    res_t              res;

    // Node count register; a write also restarts the tour.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_W'(MAX_NODES);
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_wdata;
        end
    end

    // Effective count clamped to 2..MAX_NODES.
    assign eff_n = (node_count_reg < NODE_W'(2)) ? NODE_W'(2) :
                   (node_count_reg > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) :
                   node_count_reg;

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;
    assign m_axis_tdata  = {4'b0000, res};

    ctre_front u_front (
        .s_tdata (s_axis_tdata),
        .eff_n   (eff_n),
        .cmd     (f_cmd)
    );

    ctre_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (f_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_cmd)
    );

    ctre_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .eff_n    (eff_n),
        .cfg_init (cfg_we),
        .q_valid  (q_valid),
        .q_data   (q_cmd),
        .q_pop    (q_pop),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_res    (res)
    );

`ifndef SYNTHESIS
    // A command leaves the queue only while the result register is empty.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !m_axis_tvalid)
        else $error("command popped while a result is pending");

    // The queue never pops while empty.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from an empty command queue");

    // The clamped node count stays in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (eff_n >= 7'd2) && (eff_n <= 7'd64))
        else $error("effective node count out of range");
`endif

endmodule
